// File: src/crcss_pkg.sv
// Shared types, codes and helpers for the CRC-32 shard selector.
`timescale 1ns / 1ps
`default_nettype none

package crcss_pkg;

	// Request codes carried on req_type
	localparam logic [1:0] REQ_STRING  = 2'd0;
	localparam logic [1:0] REQ_NUMERIC = 2'd1;
	localparam logic [1:0] REQ_EMPTY   = 2'd2;

	localparam int unsigned CNT_W     = 13;	// shard count register width
	localparam int unsigned IDX_W     = 12;	// shard index width
	localparam int unsigned HASH_W    = 32;
	localparam int unsigned KEY_W     = 64;
	localparam int unsigned ITER_W    = 7;	// holds up to 64 divide steps

	localparam logic [CNT_W-1:0]  MAX_SHARDS    = 13'd4096;
	localparam logic [CNT_W-1:0]  SHARDS_RESET  = 13'd1;
	localparam logic [HASH_W-1:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [HASH_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;

	localparam logic [ITER_W-1:0] ITERS_NUMERIC = 7'd64;
	localparam logic [ITER_W-1:0] ITERS_HASH    = 7'd32;
	localparam logic [ITER_W-1:0] ITERS_NONE    = 7'd0;

	localparam int unsigned CRCSS_QUEUE_DEPTH = 2;

	// One modulo job handed from the front to the back.
	// The dividend is left aligned: its MSB is consumed first.
	typedef struct packed {
		logic [KEY_W-1:0]  dividend;
		logic [HASH_W-1:0] hash;
		logic [ITER_W-1:0] iters;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} back_state_t;

	// Zero is treated as one shard, anything above the maximum saturates.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
		logic [CNT_W-1:0] c;
		c = raw;
		if (c == '0)
			c = SHARDS_RESET;
		else if (c > MAX_SHARDS)
			c = MAX_SHARDS;
		return c;
	endfunction

endpackage

`default_nettype wire

// File: src/crcss_front.sv
// Front end: accepts items, runs the byte-wide CRC and queues modulo jobs.
`timescale 1ns / 1ps
`default_nettype none

module crcss_front
	import crcss_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [7:0]        key_byte,
	input  wire logic              last_byte,
	input  wire logic [KEY_W-1:0]  numeric_key,
	input  wire logic              q_full,
	output logic                   q_push,
	output job_t                   q_job
);

	logic [HASH_W-1:0] crc_q;
	logic [HASH_W-1:0] crc_next;
	logic [HASH_W-1:0] hash_final;
	logic              accept;

	// Reflected CRC-32, one byte: eight shift/xor steps
	function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc,
			input logic [7:0] b);
		logic [HASH_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY_REFL;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	assign in_stall   = q_full;
	assign accept     = in_valid && !in_stall;
	assign crc_next   = crc_byte(crc_q, key_byte);
	assign hash_final = ~crc_next;

	always_comb begin
		q_push = 1'b0;
		q_job  = '{dividend: '0, hash: '0, iters: ITERS_NONE};
		unique case (req_type)
			REQ_STRING: begin
				q_push = accept && last_byte;
				q_job  = '{dividend: {hash_final, 32'd0}, hash: hash_final,
					iters: ITERS_HASH};
			end
			REQ_NUMERIC: begin
				q_push = accept;
				q_job  = '{dividend: numeric_key, hash: '0, iters: ITERS_NUMERIC};
			end
			REQ_EMPTY: begin
				q_push = accept;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (accept && req_type == REQ_STRING) begin
			crc_q <= last_byte ? CRC_INIT : crc_next;
		end
	end

endmodule

`default_nettype wire

// File: src/crcss_fifo.sv
// Short job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module crcss_fifo
	import crcss_pkg::*;
#(
	parameter int unsigned DEPTH = CRCSS_QUEUE_DEPTH
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      pop_job,
	output logic      full,
	output logic      empty
);

	localparam int unsigned PTR_W  = $clog2(DEPTH);
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	job_t              entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == FILL_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: src/crcss_back.sv
// Back end: shard count register and bit-serial modulo with output register.
`timescale 1ns / 1ps
`default_nettype none

module crcss_back
	import crcss_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CNT_W-1:0]  cfg_wr_data,
	input  wire logic              q_empty,
	input  wire job_t              q_job,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [IDX_W-1:0]       shard_index,
	output logic [HASH_W-1:0]      key_hash
);

	back_state_t       state_q;
	back_state_t       state_next;
	logic [CNT_W-1:0]  shard_count_q;
	logic [CNT_W-1:0]  divisor;
	logic [KEY_W-1:0]  div_q;
	logic [IDX_W-1:0]  rem_q;
	logic [CNT_W-1:0]  rem_shift;
	logic [CNT_W-1:0]  rem_sub;
	logic [IDX_W-1:0]  rem_next;
	logic [HASH_W-1:0] hash_q;
	logic [ITER_W-1:0] iter_q;

	assign divisor = eff_count(shard_count_q);

	// restoring step: remainder stays below the divisor (at most 4096)
	assign rem_shift = {rem_q, div_q[KEY_W-1]};
	assign rem_sub   = rem_shift - divisor;
	assign rem_next  = (rem_shift >= divisor) ? rem_sub[IDX_W-1:0] : rem_shift[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shard_count_q <= SHARDS_RESET;
		end else if (cfg_wr_en) begin
			shard_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		q_pop      = 1'b0;
		out_valid  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop      = 1'b1;
					state_next = (q_job.iters == ITERS_NONE) ? ST_OUT : ST_DIV;
				end
			end
			ST_DIV: begin
				if (iter_q == ITER_W'(1))
					state_next = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			div_q  <= q_job.dividend;
			hash_q <= q_job.hash;
			iter_q <= q_job.iters;
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			div_q  <= {div_q[KEY_W-2:0], 1'b0};
			rem_q  <= rem_next;
			iter_q <= iter_q - 1'b1;
		end
	end

	assign shard_index = rem_q;
	assign key_hash    = hash_q;

endmodule

`default_nettype wire

// File: src/crc32_key_shard_select_top.sv
// Top level of the CRC-32 key shard selector.
// Each accepted last byte, numeric key or empty key yields one result; other
//   bytes only update the CRC.
// Throughput: one item per cycle into the front while the queue has room; the
//   back end pops one job, runs its 32, 64 or 0 quotient steps and waits out stall.
// Reset (arst_n low, asynchronous): CRC to all ones, shard count 1, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module crc32_key_shard_select_top
	import crcss_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = CRCSS_QUEUE_DEPTH	// modulo jobs in flight, 2..16
)(
	input  wire logic              clk,
	input  wire logic              arst_n,

	// shard count register write
	input  wire logic              cfg_wr_en,
	input  wire logic [CNT_W-1:0]  cfg_wr_data,

	// input items
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [7:0]        key_byte,
	input  wire logic              last_byte,
	input  wire logic [KEY_W-1:0]  numeric_key,

	// result items
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [IDX_W-1:0]       shard_index,
	output logic [HASH_W-1:0]      key_hash
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	job_t push_job;
	job_t pop_job;

	// Front: CRC over key bytes; final bytes, numeric and empty keys
	// become modulo jobs. Stalls only when the queue is full.
	crcss_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.key_byte    (key_byte),
		.last_byte   (last_byte),
		.numeric_key (numeric_key),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	// Job queue decouples the byte stream from the slow modulo
	crcss_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back: bit-serial remainder; the result register holds under stall
	crcss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_empty     (q_empty),
		.q_job       (pop_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.shard_index (shard_index),
		.key_hash    (key_hash)
	);

endmodule

`default_nettype wire

// File: test/tb_crc32_key_shard_select_top.sv
// Self-checking testbench for the CRC-32 key shard selector top level.
`timescale 1ns / 1ps

module tb_crc32_key_shard_select_top;
	import crcss_pkg::*;

	// Request type 3 is not a defined request; the block must drop it.
	localparam logic [1:0] REQ_RESERVED = 2'd3;
	// The slowest result comes from a numeric key; leave some slack.
	localparam int DRAIN_CYCLES = 80;

	// One input item as it goes onto the bus
	typedef struct {
		logic [1:0]       kind;
		logic [7:0]       kb;
		logic             last;
		logic [KEY_W-1:0] nk;
	} key_item_t;

	// One predicted result item
	typedef struct packed {
		logic [IDX_W-1:0]  shard;
		logic [HASH_W-1:0] hash;
	} shard_pick_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [CNT_W-1:0]  cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [1:0]        req_type    = REQ_STRING;
	logic [7:0]        key_byte    = '0;
	logic              last_byte   = 1'b0;
	logic [KEY_W-1:0]  numeric_key = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [IDX_W-1:0]  shard_index;
	logic [HASH_W-1:0] key_hash;

	crc32_key_shard_select_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.key_byte    (key_byte),
		.last_byte   (last_byte),
		.numeric_key (numeric_key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.shard_index (shard_index),
		.key_hash    (key_hash)
	);

	// Predictor state: running CRC and our copy of the shard count register
	logic [HASH_W-1:0] crc_acc   = CRC_INIT;
	logic [CNT_W-1:0]  shard_reg = SHARDS_RESET;

	key_item_t   pending_q[$];		// items waiting for the driver
	shard_pick_t shard_expect_q[$];	// predicted results, oldest first
	key_item_t   on_bus;			// item currently presented
	int          n_queued   = 0;
	int          n_live     = 0;	// queued items that are not type 3
	int          n_accepted = 0;
	int          n_bad      = 0;
	logic [31:0] cyc        = '0;
	logic [CNT_W-1:0] shard_plan [11];

	initial forever #10 clk = ~clk;

	always @(posedge clk) cyc <= cyc + 1;

	// Idle roughly 34% of the time, except for a recurring quiet window
	// where both sides run flat out.
	function automatic logic take_break();
		if (cyc[14:12] == 3'd1)
			return 1'b0;
		return $urandom_range(0, 99) < 34;
	endfunction

	function automatic logic [KEY_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Numeric keys: a mix of small values, all ones, 32-bit and full 64-bit
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 4))
			0: return KEY_W'($urandom_range(0, 9000));
			1: return '1;
			2: return {32'd0, $urandom};
			default: return rand64();
		endcase
	endfunction

	task automatic note_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_bad++;
	endtask

	// Work out what an accepted item should produce and queue it.
	task automatic predict_shard(input key_item_t it);
		logic [KEY_W-1:0]  div;
		logic [KEY_W-1:0]  rem;
		logic [HASH_W-1:0] h;
		shard_pick_t       r;
		int                b;
		// zero counts as one shard, anything past the max saturates
		div = '0;
		if (shard_reg == '0)
			div[CNT_W-1:0] = 13'd1;
		else if (shard_reg > MAX_SHARDS)
			div[CNT_W-1:0] = MAX_SHARDS;
		else
			div[CNT_W-1:0] = shard_reg;
		case (it.kind)
			REQ_STRING: begin
				crc_acc = crc_acc ^ {24'd0, it.kb};
				for (b = 0; b < 8; b++)
					crc_acc = crc_acc[0] ? (crc_acc >> 1) ^ CRC_POLY_REFL : crc_acc >> 1;
				// only the last byte of a key yields a result
				if (it.last) begin
					h = ~crc_acc;
					crc_acc = CRC_INIT;
					rem = {32'd0, h} % div;
					r.shard = rem[IDX_W-1:0];
					r.hash = h;
					shard_expect_q = {shard_expect_q, r};
				end
			end
			REQ_NUMERIC: begin
				// running CRC untouched: a partial string key carries on
				rem = it.nk % div;
				r.shard = rem[IDX_W-1:0];
				r.hash = '0;
				shard_expect_q = {shard_expect_q, r};
			end
			REQ_EMPTY: begin
				r = '0;
				shard_expect_q = {shard_expect_q, r};
			end
			default: ;	// reserved type: no result, no state change
		endcase
	endtask

	// Driver: present the next pending item whenever the slot frees up.
	// Payload and valid hold while stalled; raising valid never waits on stall.
	always @(posedge clk) begin : drive
		logic slot_free;
		slot_free = !in_valid || !in_stall;
		if (in_valid && !in_stall) begin
			predict_shard(on_bus);
			n_accepted++;
		end
		if (slot_free) begin
			if (pending_q.size() != 0 && !take_break()) begin
				on_bus = pending_q.pop_front();
				in_valid    <= 1'b1;
				req_type    <= on_bus.kind;
				key_byte    <= on_bus.kb;
				last_byte   <= on_bus.last;
				numeric_key <= on_bus.nk;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction,
	// then pick the stall for the next cycle.
	always @(posedge clk) begin : watch
		shard_pick_t want;
		if (out_valid && !out_stall) begin
			if (shard_expect_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result shard_index %0d key_hash %08h",
					shard_index, key_hash));
			end else begin
				want = shard_expect_q.pop_front();
				if (shard_index !== want.shard)
					note_mismatch($sformatf("shard_index %0d, predicted %0d",
						shard_index, want.shard));
				if (key_hash !== want.hash)
					note_mismatch($sformatf("key_hash %08h, predicted %08h",
						key_hash, want.hash));
			end
		end
		out_stall <= take_break();
	end

	task automatic push_item(input logic [1:0] kind, input logic [7:0] kb,
		input logic last, input logic [KEY_W-1:0] nk);
		key_item_t it;
		it.kind = kind;
		it.kb = kb;
		it.last = last;
		it.nk = nk;
		pending_q = {pending_q, it};
		n_queued++;
		if (kind != REQ_RESERVED)
			n_live++;
	endtask

	// A string key of random length and content; with cut_in set, a numeric,
	// empty or reserved item lands right after one of its bytes.
	task automatic push_string(input logic cut_in);
		int len;
		int cut_at;
		int i;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		cut_at = cut_in ? $urandom_range(0, len - 1) : -1;
		for (i = 0; i < len; i++) begin
			push_item(REQ_STRING, 8'($urandom_range(0, 255)), i == len - 1, rand64());
			if (i == cut_at) begin
				case ($urandom_range(0, 2))
					0: push_item(REQ_NUMERIC, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), pick_key());
					1: push_item(REQ_EMPTY, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), rand64());
					default: push_item(REQ_RESERVED, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), rand64());
				endcase
			end
		end
	endtask

	// Mostly complete string keys; the rest numeric, empty and noise.
	task automatic add_random(input int n);
		int start;
		int pick;
		start = n_live;
		while (n_live - start < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				push_string(1'b0);
			else if (pick < 65)
				push_string(1'b1);
			else if (pick < 83)
				push_item(REQ_NUMERIC, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), pick_key());
			else if (pick < 94)
				push_item(REQ_EMPTY, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), rand64());
			else
				push_item(REQ_RESERVED, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), rand64());
		end
	endtask

	// Wait for every item to go in and every result to come out, then give
	// the back end time to settle before touching the register.
	task automatic drain_phase();
		do
			@(negedge clk);
		while (n_accepted != n_queued || in_valid || shard_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_shards(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shard_reg = v;
		@(negedge clk);
	endtask

	// Stimulus: items are queued off the rising edge so the driver sees them
	// at a clean edge.
	initial begin : stim
		int i;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// shard count still at its reset value
		add_random(20);
		drain_phase();

		set_shards(13'd1000);
		// directed: empty key, numeric extremes, single-byte keys
		push_item(REQ_EMPTY, 8'hFF, 1'b1, '1);
		push_item(REQ_NUMERIC, 8'h00, 1'b0, '0);
		push_item(REQ_NUMERIC, 8'hFF, 1'b1, '1);
		push_item(REQ_NUMERIC, 8'hA5, 1'b0, 64'h8000_0000_0000_0000);
		push_item(REQ_STRING, 8'h00, 1'b1, '0);
		push_item(REQ_STRING, 8'hFF, 1'b1, '1);
		// the usual "123456789" check string
		for (i = 0; i < 9; i++)
			push_item(REQ_STRING, 8'(8'h31 + i), i == 8, '0);
		// string key with numeric, empty and reserved items in the middle
		push_item(REQ_STRING, 8'h61, 1'b0, '1);
		push_item(REQ_STRING, 8'h62, 1'b0, '1);
		push_item(REQ_NUMERIC, 8'h63, 1'b1, 64'd12345);
		push_item(REQ_EMPTY, 8'h64, 1'b0, '1);
		push_item(REQ_RESERVED, 8'h65, 1'b1, '1);
		push_item(REQ_STRING, 8'h63, 1'b1, '0);
		// reserved type on its own
		push_item(REQ_RESERVED, 8'hFF, 1'b1, '1);
		add_random(100);
		drain_phase();

		// zero and oversize counts, the extremes, and a couple of random ones
		shard_plan = '{13'd0, MAX_SHARDS, 13'd8191, 13'd4097, 13'd1, 13'd2, 13'd3,
			13'd4095, 13'd37, 13'd0, 13'd0};
		shard_plan[9] = CNT_W'($urandom_range(1, 4096));
		shard_plan[10] = CNT_W'($urandom_range(0, 8191));
		for (i = 0; i < 11; i++) begin
			set_shards(shard_plan[i]);
			add_random(110);
			drain_phase();
		end

		if (n_bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
